@@ src/ost_pkg.sv @@
// shared constants and types for the oversampled serial transceiver
// no dependencies; imported by ost_rx, ost_tx and the top level
package ost_pkg;

    // default line timing
    localparam int TICKS_PER_BIT_DEF = 8;
    localparam int DATA_BITS_DEF     = 8;

    // width of the byte fields on the ports
    localparam int BYTE_W = 8;

    // receiver result for one tick
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } rx_result_t;

    // transmitter status for one tick
    typedef struct packed {
        logic level;
        logic busy;
    } tx_status_t;

endpackage

@@ src/ost_rx.sv @@
// receive side: edge search, mid-bit sampling and byte assembly
// depends on ost_pkg for the result type
module ost_rx #(
    parameter int TICKS_PER_BIT = ost_pkg::TICKS_PER_BIT_DEF,
    parameter int DATA_BITS     = ost_pkg::DATA_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   line,
    output ost_pkg::rx_result_t    res
);
    import ost_pkg::*;

    localparam int FIRST_WAIT = TICKS_PER_BIT / 2 + TICKS_PER_BIT;
    localparam int CNT_W      = $clog2(FIRST_WAIT + 1);
    localparam int BIT_W      = (DATA_BITS > 2) ? $clog2(DATA_BITS) : 1;

    localparam logic [1:0] RX_WAIT_HIGH = 2'd0;
    localparam logic [1:0] RX_WAIT_LOW  = 2'd1;
    localparam logic [1:0] RX_DATA      = 2'd2;

    localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(FIRST_WAIT);
    localparam logic [CNT_W-1:0] CNT_BIT   = CNT_W'(TICKS_PER_BIT);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [BIT_W-1:0] BIT_LAST  = BIT_W'(DATA_BITS - 1);

    logic [1:0]           phase_reg, phase_next;
    logic [CNT_W-1:0]     tick_reg, tick_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic                 done;

    // next state for one tick
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        done       = 1'b0;
        case (phase_reg)
            RX_DATA:
            begin
                if (tick_reg == CNT_ONE)
                begin
                    shift_next = {line, shift_reg[DATA_BITS-1:1]};
                    tick_next  = CNT_BIT;
                    if (bit_reg == BIT_LAST)
                    begin
                        done       = 1'b1;
                        bit_next   = '0;
                        phase_next = line ? RX_WAIT_LOW : RX_WAIT_HIGH;
                    end
                    else
                    begin
                        bit_next = bit_reg + BIT_W'(1);
                    end
                end
                else
                begin
                    tick_next = tick_reg - CNT_ONE;
                end
            end
            RX_WAIT_LOW:
            begin
                if (!line)
                begin
                    phase_next = RX_DATA;
                    tick_next  = CNT_FIRST;
                    bit_next   = '0;
                    shift_next = '0;
                end
            end
            default:
            begin
                phase_next = line ? RX_WAIT_LOW : RX_WAIT_HIGH;
            end
        endcase
    end

    // result of this tick, byte shown only on completion
    assign res.valid = done;
    assign res.data  = done ? BYTE_W'(shift_next) : '0;

    // state registers advance once per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= RX_WAIT_HIGH;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
        end
    end

endmodule

@@ src/ost_tx.sv @@
// transmit side: start level, inverted data bits and stop level sequencing
// depends on ost_pkg for the status type and byte width
module ost_tx #(
    parameter int TICKS_PER_BIT = ost_pkg::TICKS_PER_BIT_DEF,
    parameter int DATA_BITS     = ost_pkg::DATA_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        start,
    input  logic [ost_pkg::BYTE_W-1:0]  data,
    output ost_pkg::tx_status_t         status
);
    import ost_pkg::*;

    localparam int TICK_W = $clog2(TICKS_PER_BIT);
    localparam int BIT_W  = $clog2(DATA_BITS + 1);

    localparam logic [1:0] TX_IDLE  = 2'd0;
    localparam logic [1:0] TX_START = 2'd1;
    localparam logic [1:0] TX_DATA  = 2'd2;
    localparam logic [1:0] TX_STOP  = 2'd3;

    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_BIT - 1);
    localparam logic [BIT_W-1:0]  BIT_ALL   = BIT_W'(DATA_BITS);

    logic [1:0]           phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic                 line_reg, line_next;

    // next state for one tick
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        line_next  = line_reg;
        if (phase_reg != TX_IDLE)
        begin
            if (tick_reg == TICK_LAST)
            begin
                tick_next = '0;
                case (phase_reg)
                    TX_START:
                    begin
                        phase_next = TX_DATA;
                        line_next  = ~shift_reg[0];
                        shift_next = {1'b0, shift_reg[DATA_BITS-1:1]};
                        bit_next   = BIT_W'(1);
                    end
                    TX_DATA:
                    begin
                        if (bit_reg < BIT_ALL)
                        begin
                            line_next  = ~shift_reg[0];
                            shift_next = {1'b0, shift_reg[DATA_BITS-1:1]};
                            bit_next   = bit_reg + BIT_W'(1);
                        end
                        else
                        begin
                            phase_next = TX_STOP;
                            line_next  = 1'b0;
                        end
                    end
                    default:
                    begin
                        phase_next = TX_IDLE;
                        line_next  = 1'b0;
                    end
                endcase
            end
            else
            begin
                tick_next = tick_reg + TICK_W'(1);
            end
        end
        // new request, also taken on the tick that ends the stop level
        if (phase_next == TX_IDLE && start)
        begin
            phase_next = TX_START;
            tick_next  = '0;
            bit_next   = '0;
            shift_next = data[DATA_BITS-1:0];
            line_next  = 1'b1;
        end
    end

    assign status.level = line_next;
    assign status.busy  = (phase_next != TX_IDLE);

    // state registers advance once per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= TX_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            line_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            line_reg  <= line_next;
        end
    end

endmodule

@@ src/oversampled_serial_transceiver.sv @@
// Oversampled serial transceiver: each input transfer is one oversampling tick carrying the
// receive line level and an optional transmit request, and it yields exactly one output
// transfer with the driven transmit level, the busy flag and, on the tick that completes
// a byte, the received byte with rx_valid. A tick is taken every clock cycle while in_stall
// is low, and its result appears in the output register on the next cycle; the one
// output register is refilled in the same cycle it is taken, so the input stalls only while
// a result waits and out_stall is high. No clearing pass is needed after reset.
// Depends on ost_pkg, ost_rx and ost_tx.
module oversampled_serial_transceiver #(
    parameter int TICKS_PER_BIT = ost_pkg::TICKS_PER_BIT_DEF,
    parameter int DATA_BITS     = ost_pkg::DATA_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        rx_line,
    input  logic                        tx_start,
    input  logic [ost_pkg::BYTE_W-1:0]  tx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        tx_level,
    output logic [ost_pkg::BYTE_W-1:0]  rx_byte,
    output logic                        rx_valid,
    output logic                        tx_busy
);
    import ost_pkg::*;

    logic              step;
    rx_result_t        rx_res;
    tx_status_t        tx_stat;
    logic              out_valid_reg;
    logic              tx_level_reg;
    logic [BYTE_W-1:0] rx_byte_reg;
    logic              rx_valid_reg;
    logic              tx_busy_reg;

    // a transfer is taken whenever the output register is free or being emptied
    assign in_stall = out_valid_reg & out_stall;
    assign step     = in_valid & ~in_stall;

    ost_rx #(
        .TICKS_PER_BIT (TICKS_PER_BIT),
        .DATA_BITS     (DATA_BITS)
    ) u_rx (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .line  (rx_line),
        .res   (rx_res)
    );

    ost_tx #(
        .TICKS_PER_BIT (TICKS_PER_BIT),
        .DATA_BITS     (DATA_BITS)
    ) u_tx (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .start  (tx_start),
        .data   (tx_byte),
        .status (tx_stat)
    );

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            tx_level_reg <= tx_stat.level;
            tx_busy_reg  <= tx_stat.busy;
            rx_valid_reg <= rx_res.valid;
            rx_byte_reg  <= rx_res.data;
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_level  = tx_level_reg;
    assign rx_byte   = rx_byte_reg;
    assign rx_valid  = rx_valid_reg;
    assign tx_busy   = tx_busy_reg;

endmodule

@@ dv/ost_checker.sv @@
// line-level checker for the oversampled serial transceiver: watches both channels,
// predicts each tick's outputs and compares them in order; depends on ost_pkg only
`timescale 1ns / 100ps

module ost_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       rx_line,
    input  logic                       tx_start,
    input  logic [ost_pkg::BYTE_W-1:0] tx_byte,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic                       tx_level,
    input  logic [ost_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       rx_valid,
    input  logic                       tx_busy,
    output int                         fail_count,
    output int                         ticks_outstanding
);
    import ost_pkg::*;

    localparam int TPB = TICKS_PER_BIT_DEF;
    localparam int NBITS = DATA_BITS_DEF;

    typedef enum logic [1:0] {RX_HUNT_HIGH, RX_HUNT_EDGE, RX_SAMPLE} rx_mode_t;
    typedef enum logic [1:0] {TX_IDLE, TX_START_BIT, TX_DATA_BITS, TX_STOP_BIT} tx_mode_t;

    typedef struct packed {
        logic              tx_level;
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_valid;
        logic              tx_busy;
    } tick_result_t;

    // predictor copy of the line state
    rx_mode_t          rx_mode;
    int                rx_countdown;
    int                rx_bits_seen;
    logic [BYTE_W-1:0] rx_shreg;
    tx_mode_t          tx_mode;
    int                tx_ticks;
    int                tx_bits_sent;
    logic [BYTE_W-1:0] tx_shreg;
    logic              tx_line;

    tick_result_t expected_ticks[$];
    tick_result_t due;
    tick_result_t seen;
    int           errors = 0;

    assign fail_count = errors;

    // next data bit goes out inverted, lsb first
    function automatic void shift_out_bit();
        tx_line = ~tx_shreg[0];
        tx_shreg = tx_shreg >> 1;
        tx_bits_sent++;
    endfunction

    // one oversampling tick of receiver and transmitter
    task automatic predict_tick(input logic line, input logic start,
                                input logic [BYTE_W-1:0] data, output tick_result_t res);
        res = '0;
        case (rx_mode)
            RX_SAMPLE:
            begin
                rx_countdown--;
                if (rx_countdown == 0)
                begin
                    rx_shreg = (rx_shreg >> 1) | (BYTE_W'(line) << (NBITS - 1));
                    rx_bits_seen++;
                    rx_countdown = TPB;
                    if (rx_bits_seen >= NBITS)
                    begin
                        // a high completing sample already arms the edge search
                        res.rx_valid = 1'b1;
                        res.rx_byte = rx_shreg;
                        rx_bits_seen = 0;
                        rx_mode = line ? RX_HUNT_EDGE : RX_HUNT_HIGH;
                    end
                end
            end
            RX_HUNT_EDGE:
            begin
                if (!line)
                begin
                    rx_mode = RX_SAMPLE;
                    rx_countdown = TPB / 2 + TPB;
                    rx_bits_seen = 0;
                    rx_shreg = '0;
                end
            end
            default:
                rx_mode = line ? RX_HUNT_EDGE : RX_HUNT_HIGH;
        endcase

        if (tx_mode != TX_IDLE)
        begin
            tx_ticks++;
            if (tx_ticks >= TPB)
            begin
                tx_ticks = 0;
                case (tx_mode)
                    TX_START_BIT:
                    begin
                        tx_mode = TX_DATA_BITS;
                        tx_bits_sent = 0;
                        shift_out_bit();
                    end
                    TX_DATA_BITS:
                    begin
                        if (tx_bits_sent < NBITS)
                            shift_out_bit();
                        else
                        begin
                            tx_mode = TX_STOP_BIT;
                            tx_line = 1'b0;
                        end
                    end
                    default:
                    begin
                        tx_mode = TX_IDLE;
                        tx_line = 1'b0;
                    end
                endcase
            end
        end
        // a request on the tick that ends the stop bit starts straight away
        if (tx_mode == TX_IDLE && start)
        begin
            tx_mode = TX_START_BIT;
            tx_ticks = 0;
            tx_bits_sent = 0;
            tx_shreg = data;
            tx_line = 1'b1;
        end

        res.tx_level = tx_line;
        res.tx_busy = (tx_mode != TX_IDLE);
    endtask

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    // retire output transfers first, then predict the input transfer of this edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_mode = RX_HUNT_HIGH;
            rx_countdown = 0;
            rx_bits_seen = 0;
            rx_shreg = '0;
            tx_mode = TX_IDLE;
            tx_ticks = 0;
            tx_bits_sent = 0;
            tx_shreg = '0;
            tx_line = 1'b0;
            expected_ticks.delete();
            ticks_outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{tx_level, rx_byte, rx_valid, tx_busy};
                if (expected_ticks.size() == 0)
                begin
                    $display("%0t: unexpected output transfer, expected none actual %0h",
                             $time, seen);
                    errors++;
                end
                else
                begin
                    due = expected_ticks.pop_front();
                    check_field("tx_level", due.tx_level, seen.tx_level);
                    check_field("rx_byte", due.rx_byte, seen.rx_byte);
                    check_field("rx_valid", due.rx_valid, seen.rx_valid);
                    check_field("tx_busy", due.tx_busy, seen.tx_busy);
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_tick(rx_line, tx_start, tx_byte, due);
                expected_ticks.push_back(due);
            end
            ticks_outstanding <= expected_ticks.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
// top of the transceiver testbench: clock, reset, tick stimulus with serial frames,
// output back-pressure and the verdict; depends on ost_pkg, the block and ost_checker
`timescale 1ns / 100ps

module testbench;
    import ost_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              rx_line = 1'b1;
    logic              tx_start = 1'b0;
    logic [BYTE_W-1:0] tx_byte = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              tx_level;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_valid;
    logic              tx_busy;
    int                fail_count;
    int                ticks_outstanding;

    localparam int TPB = TICKS_PER_BIT_DEF;
    localparam int RANDOM_TICKS = 130;

    // planned receive line levels, one per tick
    logic rx_plan[$];
    // transmit request policy for the ticks being sent
    logic              tx_hold;
    int                tx_pct;
    logic              tx_pin;
    logic [BYTE_W-1:0] tx_pin_byte;
    int                burst_left = 0;
    int                ticks_sent = 0;
    int                stall_mode = 0;
    int                stall_cnt = 0;

    oversampled_serial_transceiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_line   (rx_line),
        .tx_start  (tx_start),
        .tx_byte   (tx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tx_level  (tx_level),
        .rx_byte   (rx_byte),
        .rx_valid  (rx_valid),
        .tx_busy   (tx_busy)
    );

    ost_checker u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_line           (rx_line),
        .tx_start          (tx_start),
        .tx_byte           (tx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .tx_level          (tx_level),
        .rx_byte           (rx_byte),
        .rx_valid          (rx_valid),
        .tx_busy           (tx_busy),
        .fail_count        (fail_count),
        .ticks_outstanding (ticks_outstanding)
    );

    always #4 clk = ~clk;

    // output back-pressure: the stall pattern is one of four, re-picked at random as the run goes on
    always @(posedge clk)
    begin
        if (stall_cnt % 50 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_cnt % 16) < 10);
        endcase
        stall_cnt++;
    end

    // one tick transfer, sent in bursts with random gaps between them
    task automatic send_tick(input logic line, input logic start, input logic [BYTE_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        rx_line <= line;
        tx_start <= start;
        tx_byte <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        ticks_sent++;
    endtask

    // serial frame on the receive line: idle high, start low, data lsb first, stop high
    task automatic plan_frame(input logic [BYTE_W-1:0] value, input int bit_len,
                              input int idle, input int stop_len);
        repeat (idle) rx_plan.push_back(1'b1);
        repeat (bit_len) rx_plan.push_back(1'b0);
        for (int i = 0; i < BYTE_W; i++)
            repeat (bit_len) rx_plan.push_back(value[i]);
        repeat (stop_len) rx_plan.push_back(1'b1);
    endtask

    // send every planned tick with transmit requests per the current policy
    task automatic drain_plan();
        logic start;
        logic [BYTE_W-1:0] data;
        while (rx_plan.size() > 0)
        begin
            start = tx_hold ? 1'b1 : ($urandom_range(0, 99) < tx_pct);
            data = tx_pin ? tx_pin_byte : BYTE_W'($urandom_range(0, 255));
            send_tick(rx_plan.pop_front(), start, data);
        end
    endtask

    // hold the sender off until every expected transfer has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (ticks_outstanding != 0) @(posedge clk);
    endtask

    initial
    begin
        int random_start;
        int kind;
        int keep;
        int waited;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: byte extremes both ways, requests held high so sends run back to back
        // and requests land while busy, high and low completing samples
        tx_hold = 1'b1;
        tx_pct = 0;
        tx_pin = 1'b1;
        tx_pin_byte = 8'h00;
        plan_frame(8'h00, TPB, 3, TPB);
        drain_plan();
        tx_pin_byte = 8'hFF;
        plan_frame(8'hFF, TPB, 0, TPB);
        drain_plan();
        tx_pin = 1'b0;
        plan_frame(8'h80, TPB, 0, 0);
        plan_frame(8'h5A, TPB, 0, TPB);
        drain_plan();
        tx_hold = 1'b0;
        plan_frame(8'hA5, TPB, 1, TPB);
        drain_plan();
        drain_results();

        // random: mostly well-formed frames, some cut short, some line noise
        random_start = ticks_sent;
        while (ticks_sent - random_start < RANDOM_TICKS)
        begin
            tx_hold = ($urandom_range(0, 4) == 0);
            tx_pct = $urandom_range(0, 20);
            tx_pin = 1'b0;
            kind = $urandom_range(0, 99);
            if (kind < 85)
            begin
                plan_frame(BYTE_W'($urandom_range(0, 255)),
                           ($urandom_range(0, 5) == 0) ? $urandom_range(TPB - 1, TPB + 1) : TPB,
                           $urandom_range(0, 6),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, TPB - 1) : TPB);
                if (kind >= 70)
                begin
                    keep = $urandom_range(1, rx_plan.size() - 1);
                    while (rx_plan.size() > keep) void'(rx_plan.pop_back());
                end
            end
            else
                repeat ($urandom_range(4, 30)) rx_plan.push_back(1'($urandom_range(0, 1)));
            drain_plan();
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end

        // wait for the last transfers, up to a limit, then let the clock run on before the verdict
        in_valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (ticks_outstanding != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (fail_count == 0 && ticks_outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // overall run limit
    initial
    begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ oversampled_serial_transceiver.f @@
src/ost_pkg.sv
src/ost_rx.sv
src/ost_tx.sv
src/oversampled_serial_transceiver.sv
dv/ost_checker.sv
dv/testbench.sv
